[sv/rth_pkg.sv]
package rth_pkg;

	// Divider geometry: every divider produces QUO_W quotient bits.
	localparam int QUO_W     = 17;
	localparam int SDEN_W    = 9;
	localparam int SNUM_W    = SDEN_W + QUO_W;
	localparam int HUE_W     = 15;
	localparam int FRAC_W    = 17;
	localparam int HUE_FULL  = 23040;

	// Reciprocal of 255 scaled by 2^23, exact for dividends below 66052.
	localparam logic [15:0] LIGHT_RECIP = 16'd32897;

	// Hue offsets in 1/64-degree units for each dominant channel.
	localparam logic [14:0] BASE_RED   = 15'd23040;
	localparam logic [14:0] BASE_GREEN = 15'd7680;
	localparam logic [14:0] BASE_BLUE  = 15'd15360;

	// Work handed from the classifier to the divider pipeline.
	typedef struct packed {
		logic [SNUM_W-1:0] sat_num;
		logic [SDEN_W-1:0] sat_den;
		logic [SNUM_W-1:0] hue_num;
		logic [SDEN_W-1:0] hue_den;
		logic [FRAC_W-1:0] light;
	} work_t;

endpackage

[sv/rth_front.sv]
module rth_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [23:0]         in_data,
	output logic                out_valid,
	input  logic                out_pop,
	output rth_pkg::work_t      out_work
);
	import rth_pkg::*;

	logic [7:0] red, green, blue;
	logic [7:0] mn, mx;
	logic [1:0] dom;
	logic [8:0] sum;
	logic [7:0] dlt;
	logic [7:0] sden;
	logic signed [8:0] diff;
	logic [14:0] base;
	logic signed [24:0] hnum;
	logic [15:0] lrem;
	logic [31:0] lprod;
	work_t wk;

	work_t  mem_q [2];
	logic   wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic   push, pop;

	assign red   = in_data[7:0];
	assign green = in_data[15:8];
	assign blue  = in_data[23:16];

	// Find the extremes and the dominant channel, then build the division operands.
	always_comb begin
		if (red < green) begin
			mn = red; mx = green; dom = 2'd1;
		end else begin
			mn = green; mx = red; dom = 2'd0;
		end
		if (blue < mn) begin
			mn = blue;
		end else if (blue > mx) begin
			mx = blue; dom = 2'd2;
		end
		sum  = {1'b0, mn} + {1'b0, mx};
		dlt  = mx - mn;
		sden = (sum <= 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
		case (dom)
			2'd0: begin
				diff = $signed({1'b0, green}) - $signed({1'b0, blue}); base = BASE_RED;
			end
			2'd1: begin
				diff = $signed({1'b0, blue}) - $signed({1'b0, red}); base = BASE_GREEN;
			end
			default: begin
				diff = $signed({1'b0, red}) - $signed({1'b0, green}); base = BASE_BLUE;
			end
		endcase
		hnum = 25'(diff) * 25'sd3840 + $signed({10'b0, base}) * $signed({17'b0, dlt});
		if (dlt == 8'd0) begin
			// Gray pixels divide zero by two so hue and saturation come out zero.
			wk.sat_num = '0;
			wk.sat_den = SDEN_W'(2);
			wk.hue_num = '0;
			wk.hue_den = SDEN_W'(2);
		end else begin
			wk.sat_num = SNUM_W'({dlt, 17'b0}) + SNUM_W'(sden);
			wk.sat_den = {sden, 1'b0};
			wk.hue_num = SNUM_W'({hnum[23:0], 1'b0}) + SNUM_W'(dlt);
			wk.hue_den = {dlt, 1'b0};
		end
		// Lightness is sum * 32768 / 255 rounded; split off 128 * sum and divide the
		// small remainder part by 255 with a reciprocal multiply.
		lrem     = {sum, 7'b0} + 16'd127;
		lprod    = 32'(lrem) * 32'(LIGHT_RECIP);
		wk.light = FRAC_W'({sum, 7'b0}) + FRAC_W'(lprod[31:23]);
	end

	// Two-entry queue that decouples acceptance from the divider pipeline.
	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = out_pop && out_valid;
	assign out_work  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

[sv/rth_div.sv]
module rth_div #(
	parameter int DW = 9,
	parameter int QW = 17
) (
	input  logic             clk,
	input  logic             en,
	input  logic [DW+QW-1:0] num,
	input  logic [DW-1:0]    den,
	output logic [QW-1:0]    quo
);

	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] low_s [QW];
	logic [DW-1:0] den_s [QW];

	// One quotient bit per stage: shift the remainder left and subtract when it fits.
	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0] rem_i, den_i;
		logic [QW-1:0] low_i;
		logic [DW:0]   trial;
		logic          fits;

		if (k == 0) begin : g_first
			assign rem_i = num[DW+QW-1:QW];
			assign low_i = num[QW-1:0];
			assign den_i = den;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign low_i = low_s[k-1];
			assign den_i = den_s[k-1];
		end

		assign trial = {rem_i, low_i[QW-1]};
		assign fits  = trial >= {1'b0, den_i};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= fits ? DW'(trial - {1'b0, den_i}) : trial[DW-1:0];
				low_s[k] <= {low_i[QW-2:0], fits};
				den_s[k] <= den_i;
			end
		end
	end

	assign quo = low_s[QW-1];

endmodule

[sv/rth_back.sv]
module rth_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_pop,
	input  rth_pkg::work_t in_work,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [48:0]    out_data
);
	import rth_pkg::*;

	logic              en;
	logic [QUO_W-1:0]  vld_s;
	logic              vld_q;
	logic [QUO_W-1:0]  sat_quo, hue_quo;
	logic [FRAC_W-1:0] light_s [QUO_W];
	logic [HUE_W-1:0]  hue_wrap;
	logic [48:0]       data_q;

	// The whole pipeline moves whenever the output register is free or being taken.
	assign en     = !vld_q || out_ready;
	assign in_pop = en;

	rth_div #(.DW(SDEN_W), .QW(QUO_W)) u_sat (
		.clk(clk), .en(en), .num(in_work.sat_num), .den(in_work.sat_den), .quo(sat_quo)
	);

	rth_div #(.DW(SDEN_W), .QW(QUO_W)) u_hue (
		.clk(clk), .en(en), .num(in_work.hue_num), .den(in_work.hue_den), .quo(hue_quo)
	);

	// Lightness is already final; delay it to line up with the dividers.
	always_ff @(posedge clk) begin
		if (en) begin
			light_s[0] <= in_work.light;
			for (int k = 1; k < QUO_W; k++) begin
				light_s[k] <= light_s[k-1];
			end
		end
	end

	// A full turn of hue wraps back to zero.
	assign hue_wrap = (hue_quo >= QUO_W'(HUE_FULL)) ? HUE_W'(hue_quo - QUO_W'(HUE_FULL))
		: hue_quo[HUE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			vld_q <= 1'b0;
		end else if (en) begin
			vld_s <= {vld_s[QUO_W-2:0], in_valid};
			vld_q <= vld_s[QUO_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= {light_s[QUO_W-1], sat_quo, hue_wrap};
		end
	end

	assign out_valid = vld_q;
	assign out_data  = data_q;

endmodule

[sv/rgb_to_hsl.sv]
// RGB to HSL pixel converter.
// Input beats arrive on the s_ channel: one RGB pixel, 8 bits per channel, per beat.
// Output beats leave on the m_ channel: hue in 1/64-degree units, and
// saturation and lightness as unsigned fractions where 65536 is 1.0.
// A classifier finds min, max and the dominant channel, computes the
// lightness with a reciprocal multiply, and writes the division operands
// into a two-entry queue; the back end runs two restoring dividers of
// 17 stages, one quotient bit per stage, and delays the lightness to match.
// An accepted input beat passes through the queue, the divider stages
// and the output register on its way out. Throughput is one pixel per
// cycle when the output is not stalled, set by the pipelined dividers.
// When m_tready is low with an output beat pending, the divider pipeline
// and output register hold; the queue keeps taking pixels until both its
// entries are full, and then s_tready drops.
// Reset empties the queue and clears all valid flags; no output beat is
// pending after reset.
module rgb_to_hsl (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // hue_out [14:0], sat_out [31:15], light_out [48:32]
);
	import rth_pkg::*;

	logic  q_valid, q_pop;
	work_t q_work;
	logic [48:0] res;

	rth_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
		.out_valid(q_valid), .out_pop(q_pop), .out_work(q_work)
	);

	rth_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(q_valid), .in_pop(q_pop), .in_work(q_work),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_data(res)
	);

	assign m_tdata = {7'b0, res};

endmodule
